/* hw/rtl/square_wave_sound_channel_defines.svh */
// Assertion macros shared by the square-wave channel checkers.
`ifndef SQUARE_WAVE_SOUND_CHANNEL_DEFINES_SVH
`define SQUARE_WAVE_SOUND_CHANNEL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SQW_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("square wave channel check failed");

// The consequent must hold in the cycle after the antecedent.
`define SQW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("square wave channel check failed");

`endif

/* hw/rtl/sqw_pkg.sv */
// Shared types, codes and constants of the square-wave sound channel.
package sqw_pkg;

  localparam int unsigned KIND_W      = 3;
  localparam int unsigned OFF_W       = 3;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned CYC_W       = 8;
  localparam int unsigned SAMPLE_W    = 4;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned PERIOD_W    = 11;
  localparam int unsigned PC_W        = 16;

  // Longest advance that one beat may request.
  localparam int unsigned MAX_STEP_CYCLES = 255;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register reset values and field masks.
  localparam logic               HAS_SWEEP_RST   = 1'b1;
  localparam logic [CFG_DATA_W-1:0] DUTY_RST     = 32'd2122809601;
  localparam logic [DATA_W-1:0]  ENV_ACTIVE_MASK = 8'b1111_1000;
  localparam logic [DATA_W-1:0]  LEN_RD_MASK     = 8'b1100_0000;
  localparam logic [DATA_W-1:0]  HIGH_RD_MASK    = 8'b0100_0000;
  localparam logic [PERIOD_W:0]  PERIOD_MAX      = 12'h7FF;
  localparam logic [PERIOD_W:0]  PERIOD_SPAN     = 12'd2048;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE   = 3'd0,
    KIND_READ    = 3'd1,
    KIND_ADVANCE = 3'd2,
    KIND_ENV     = 3'd3,
    KIND_LEN     = 3'd4,
    KIND_SWEEP   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_READ    = 3'd2,
    OP_ADVANCE = 3'd3,
    OP_ENV     = 3'd4,
    OP_LEN     = 3'd5,
    OP_SWEEP   = 3'd6
  } op_e;

  typedef enum logic [OFF_W-1:0] {
    OFF_SWEEP  = 3'd0,
    OFF_LENGTH = 3'd1,
    OFF_VOLUME = 3'd2,
    OFF_LOW    = 3'd3,
    OFF_HIGH   = 3'd4
  } off_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HAS_SWEEP = 1'd0,
    CFG_DUTY      = 1'd1
  } cfg_idx_e;

  // One classified item as it waits in the queue.
  typedef struct packed {
    op_e               op;
    logic [OFF_W-1:0]  reg_offset;
    logic [DATA_W-1:0] write_data;
    logic [CYC_W-1:0]  cycles;
  } item_t;

  // Queue occupancy seen by its neighbours.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hw/rtl/square_wave_sound_channel.sv */
// Top level of the square-wave sound channel.
//
//  Channel  Direction  Handshake             Payload
//  in       input      in_valid_i/in_stall_o   kind, reg_offset, write_data, cycles
//  out      output     out_valid_o/out_stall_i read_data, handled, sample, channel_on
//  cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// One event is accepted per cycle while the queue is not full; results are registered.
// The back end executes each event on the channel state registers.
// A two-entry queue lets the input keep flowing for two beats while the output stalls.
// Reset is asynchronous and active low; it clears all channel state and the queue.
module square_wave_sound_channel (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sqw_pkg::KIND_W-1:0]     in_kind_i,
  input  logic [sqw_pkg::OFF_W-1:0]      in_reg_offset_i,
  input  logic [sqw_pkg::DATA_W-1:0]     in_write_data_i,
  input  logic [sqw_pkg::CYC_W-1:0]      in_cycles_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sqw_pkg::DATA_W-1:0]     out_read_data_o,
  output logic                           out_handled_o,
  output logic [sqw_pkg::SAMPLE_W-1:0]   out_sample_o,
  output logic                           out_channel_on_o,
  input  logic                           cfg_we_i,
  input  logic [sqw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sqw_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sqw_pkg::*;

  logic      push;
  logic      pop;
  item_t     item_in;
  item_t     item_out;
  q_status_t q_status;

  // Classify incoming events.
  sqw_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_kind_i       (in_kind_i),
    .in_reg_offset_i (in_reg_offset_i),
    .in_write_data_i (in_write_data_i),
    .in_cycles_i     (in_cycles_i),
    .q_status_i      (q_status),
    .push_o          (push),
    .item_o          (item_in)
  );

  // Decoupling queue.
  sqw_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (item_in),
    .pop_i    (pop),
    .item_o   (item_out),
    .status_o (q_status)
  );

  // Execute events and hold results.
  sqw_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .item_i           (item_out),
    .q_status_i       (q_status),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_read_data_o  (out_read_data_o),
    .out_handled_o    (out_handled_o),
    .out_sample_o     (out_sample_o),
    .out_channel_on_o (out_channel_on_o)
  );

endmodule

/* hw/rtl/sqw_front.sv */
// Front end: accepts input beats, classifies the event and clamps the cycle count.
module sqw_front (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sqw_pkg::KIND_W-1:0]  in_kind_i,
  input  logic [sqw_pkg::OFF_W-1:0]   in_reg_offset_i,
  input  logic [sqw_pkg::DATA_W-1:0]  in_write_data_i,
  input  logic [sqw_pkg::CYC_W-1:0]   in_cycles_i,
  input  sqw_pkg::q_status_t          q_status_i,
  output logic                        push_o,
  output sqw_pkg::item_t              item_o
);
  import sqw_pkg::*;

  op_e              op;
  logic [CYC_W-1:0] cyc;

  // Map the event kind onto an operation; unknown kinds become no-ops.
  always_comb begin
    case (in_kind_i)
      KIND_WRITE:   op = OP_WRITE;
      KIND_READ:    op = OP_READ;
      KIND_ADVANCE: op = OP_ADVANCE;
      KIND_ENV:     op = OP_ENV;
      KIND_LEN:     op = OP_LEN;
      KIND_SWEEP:   op = OP_SWEEP;
      default:      op = OP_NONE;
    endcase
  end

  // Limit the advance to the longest step allowed.
  always_comb begin
    if (int'(in_cycles_i) > int'(MAX_STEP_CYCLES)) begin
      cyc = CYC_W'(MAX_STEP_CYCLES);
    end else begin
      cyc = in_cycles_i;
    end
  end

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  assign item_o.op         = op;
  assign item_o.reg_offset = in_reg_offset_i;
  assign item_o.write_data = in_write_data_i;
  assign item_o.cycles     = cyc;

endmodule

/* hw/rtl/sqw_queue.sv */
// Short queue that decouples the front end from the execution back end.
module sqw_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sqw_pkg::item_t      item_i,
  input  logic                pop_i,
  output sqw_pkg::item_t      item_o,
  output sqw_pkg::q_status_t  status_o
);
  import sqw_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

/* hw/rtl/sqw_back.sv */
// Back end: holds state, executes one event per cycle unless stalled, registers the result.
module sqw_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sqw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sqw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  sqw_pkg::item_t                 item_i,
  input  sqw_pkg::q_status_t             q_status_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sqw_pkg::DATA_W-1:0]     out_read_data_o,
  output logic                           out_handled_o,
  output logic [sqw_pkg::SAMPLE_W-1:0]   out_sample_o,
  output logic                           out_channel_on_o
);
  import sqw_pkg::*;

  // Configuration registers.
  logic                  has_sweep_q;
  logic [CFG_DATA_W-1:0] duty_q;

  // Register bytes.
  logic [DATA_W-1:0] sweep_reg_q, sweep_reg_d;
  logic [DATA_W-1:0] len_reg_q, len_reg_d;
  logic [DATA_W-1:0] vol_reg_q, vol_reg_d;
  logic [DATA_W-1:0] low_reg_q, low_reg_d;
  logic [DATA_W-1:0] high_reg_q, high_reg_d;

  // Running state.
  logic                   enabled_q, enabled_d;
  logic [2:0]             duty_pos_q, duty_pos_d;
  logic signed [PC_W-1:0] pc_q, pc_d;
  logic [5:0]             len_cnt_q, len_cnt_d;
  logic [3:0]             env_cnt_q, env_cnt_d;
  logic [3:0]             volume_q, volume_d;
  logic                   vol_chg_q, vol_chg_d;
  logic [3:0]             sweep_cnt_q, sweep_cnt_d;
  logic [2:0]             sweep_pace_q, sweep_pace_d;

  // Result register.
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   rd_q, rd_d;
  logic                hd_q, hd_d;
  logic [SAMPLE_W-1:0] smp_q, smp_d;
  logic                on_q, on_d;

  // Working values.
  logic                    pop;
  logic [PERIOD_W-1:0]     period;
  logic [PERIOD_W-1:0]     sweep_delta;
  logic [PERIOD_W:0]       sweep_next;
  logic signed [PC_W+1:0]  adv_c;
  logic signed [PC_W+1:0]  adv_reload;
  logic [3:0]              env_inc;
  logic [3:0]              env_pace;
  logic [3:0]              sweep_inc;
  logic [4:0]              duty_idx;

  assign pop   = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o = pop;

  assign period      = {high_reg_q[2:0], low_reg_q};
  assign sweep_delta = period >> sweep_reg_q[2:0];
  assign sweep_next  = sweep_reg_q[3] ? ({1'b0, period} - {1'b0, sweep_delta})
                                      : ({1'b0, period} + {1'b0, sweep_delta});
  assign adv_c       = (PC_W+2)'(pc_q) - $signed({2'b00, (PC_W-CYC_W)'(0), item_i.cycles});
  assign adv_reload  = $signed((PC_W+2)'({PERIOD_SPAN - {1'b0, period}, 2'b00}));
  assign env_inc     = env_cnt_q + 1'b1;
  assign env_pace    = {1'b0, vol_reg_q[2:0]};
  assign sweep_inc   = sweep_cnt_q + 1'b1;

  // Event execution.
  always_comb begin
    logic signed [PC_W+1:0] c;
    sweep_reg_d  = sweep_reg_q;
    len_reg_d    = len_reg_q;
    vol_reg_d    = vol_reg_q;
    low_reg_d    = low_reg_q;
    high_reg_d   = high_reg_q;
    enabled_d    = enabled_q;
    duty_pos_d   = duty_pos_q;
    pc_d         = pc_q;
    len_cnt_d    = len_cnt_q;
    env_cnt_d    = env_cnt_q;
    volume_d     = volume_q;
    vol_chg_d    = vol_chg_q;
    sweep_cnt_d  = sweep_cnt_q;
    sweep_pace_d = sweep_pace_q;
    rd_d         = '0;
    hd_d         = 1'b0;
    c            = adv_c;

    case (item_i.op)
      OP_WRITE: begin
        case (item_i.reg_offset)
          OFF_SWEEP: begin
            if (has_sweep_q) begin
              sweep_reg_d = item_i.write_data;
              if (item_i.write_data[6:4] == 3'd0 || sweep_pace_q == 3'd0) begin
                sweep_pace_d = item_i.write_data[6:4];
              end
              hd_d = 1'b1;
            end
          end
          OFF_LENGTH: begin
            len_reg_d = item_i.write_data;
            len_cnt_d = item_i.write_data[5:0];
            hd_d      = 1'b1;
          end
          OFF_VOLUME: vol_reg_d = item_i.write_data;
          OFF_LOW:    low_reg_d = item_i.write_data;
          OFF_HIGH: begin
            high_reg_d = item_i.write_data;
            hd_d       = 1'b1;
            // Trigger: restart the tone with the newly written period.
            if (item_i.write_data[7]) begin
              enabled_d  = 1'b1;
              duty_pos_d = '0;
              pc_d       = $signed(PC_W'({item_i.write_data[2:0], low_reg_q}));
              volume_d   = vol_reg_q[7:4];
              vol_chg_d  = 1'b1;
              len_cnt_d  = len_reg_q[5:0];
              if (has_sweep_q) begin
                sweep_pace_d = sweep_reg_q[6:4];
              end
            end
          end
          default: ;
        endcase
      end
      OP_READ: begin
        case (item_i.reg_offset)
          OFF_SWEEP:  rd_d = sweep_reg_q;
          OFF_LENGTH: begin
            rd_d = len_reg_q & LEN_RD_MASK;
            hd_d = 1'b1;
          end
          OFF_VOLUME: rd_d = vol_reg_q;
          OFF_LOW:    rd_d = low_reg_q;
          OFF_HIGH: begin
            rd_d = high_reg_q & HIGH_RD_MASK;
            hd_d = 1'b1;
          end
          default: ;
        endcase
      end
      OP_ADVANCE: begin
        if (enabled_q) begin
          if (adv_c <= 0) begin
            c          = adv_c + adv_reload;
            duty_pos_d = duty_pos_q + 1'b1;
          end
          if (c > (PC_W+2)'(32767)) begin
            pc_d = 16'sh7FFF;
          end else if (c < -(PC_W+2)'(32768)) begin
            pc_d = 16'sh8000;
          end else begin
            pc_d = c[PC_W-1:0];
          end
        end
      end
      OP_ENV: begin
        if ((vol_reg_q & ENV_ACTIVE_MASK) == '0) begin
          enabled_d = 1'b0;
        end else if (env_inc < env_pace) begin
          env_cnt_d = env_inc;
        end else if (env_pace == '0 || !vol_chg_q) begin
          env_cnt_d = '0;
        end else begin
          env_cnt_d = env_inc - env_pace;
          if (vol_reg_q[3]) begin
            if (volume_q == 4'hF) begin
              vol_chg_d = 1'b0;
            end else begin
              volume_d = volume_q + 1'b1;
            end
          end else begin
            if (volume_q == 4'h0) begin
              vol_chg_d = 1'b0;
            end else begin
              volume_d = volume_q - 1'b1;
            end
          end
        end
      end
      OP_LEN: begin
        if (high_reg_q[6]) begin
          if (len_cnt_q == 6'd63) begin
            len_cnt_d = '0;
            enabled_d = 1'b0;
          end else begin
            len_cnt_d = len_cnt_q + 1'b1;
          end
        end
      end
      OP_SWEEP: begin
        if (has_sweep_q) begin
          if (sweep_reg_q[2:0] == 3'd0 && sweep_pace_q == 3'd0) begin
            sweep_cnt_d = '0;
          end else if (sweep_inc < {1'b0, sweep_pace_q}) begin
            sweep_cnt_d = sweep_inc;
          end else begin
            sweep_pace_d = sweep_reg_q[6:4];
            sweep_cnt_d  = '0;
            if (sweep_next > PERIOD_MAX) begin
              enabled_d = 1'b0;
            end else begin
              high_reg_d = {high_reg_q[7:3], sweep_next[10:8]};
              low_reg_d  = sweep_next[7:0];
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Sample from the state after the event.
  assign duty_idx = {len_reg_d[7:6], duty_pos_d};
  assign smp_d    = (enabled_d && duty_q[duty_idx]) ? volume_d : '0;
  assign on_d     = enabled_d;

  // Result register is loaded on a pop and emptied when its beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_sweep_q <= HAS_SWEEP_RST;
      duty_q      <= DUTY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HAS_SWEEP: has_sweep_q <= cfg_data_i[0];
        CFG_DUTY:      duty_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Channel state advances on every executed event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_reg_q  <= '0;
      len_reg_q    <= '0;
      vol_reg_q    <= '0;
      low_reg_q    <= '0;
      high_reg_q   <= '0;
      enabled_q    <= 1'b0;
      duty_pos_q   <= '0;
      pc_q         <= '0;
      len_cnt_q    <= '0;
      env_cnt_q    <= '0;
      volume_q     <= '0;
      vol_chg_q    <= 1'b0;
      sweep_cnt_q  <= '0;
      sweep_pace_q <= '0;
    end else if (pop) begin
      sweep_reg_q  <= sweep_reg_d;
      len_reg_q    <= len_reg_d;
      vol_reg_q    <= vol_reg_d;
      low_reg_q    <= low_reg_d;
      high_reg_q   <= high_reg_d;
      enabled_q    <= enabled_d;
      duty_pos_q   <= duty_pos_d;
      pc_q         <= pc_d;
      len_cnt_q    <= len_cnt_d;
      env_cnt_q    <= env_cnt_d;
      volume_q     <= volume_d;
      vol_chg_q    <= vol_chg_d;
      sweep_cnt_q  <= sweep_cnt_d;
      sweep_pace_q <= sweep_pace_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      rd_q  <= rd_d;
      hd_q  <= hd_d;
      smp_q <= smp_d;
      on_q  <= on_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_read_data_o  = rd_q;
  assign out_handled_o    = hd_q;
  assign out_sample_o     = smp_q;
  assign out_channel_on_o = on_q;

endmodule

/* hw/rtl/sqw_checker.sv */
// Port-level checker for the square-wave sound channel, bound to the top level.
`include "square_wave_sound_channel_defines.svh"

module sqw_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [sqw_pkg::DATA_W-1:0]     out_read_data_o,
  input logic                           out_handled_o,
  input logic [sqw_pkg::SAMPLE_W-1:0]   out_sample_o,
  input logic                           out_channel_on_o
);

  // A stalled result beat stays put.
  `SQW_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_read_data_o) && $stable(out_sample_o) && $stable(out_handled_o))

  // A silent channel gives a zero sample.
  `SQW_ASSERT_SAME(a_off_silent, out_valid_o && !out_channel_on_o, out_sample_o == '0)

  // Handled accesses only return the masked length and control bits.
  `SQW_ASSERT_SAME(a_handled_mask, out_valid_o && out_handled_o, out_read_data_o[5:0] == '0)

  // With the result register empty the queue always has room.
  `SQW_ASSERT_SAME(a_room_when_drained, !out_valid_o, !in_stall_o)

endmodule

bind square_wave_sound_channel sqw_checker u_sqw_checker (.*);
